>>> hdl/lc3_instruction_core_macros.svh
// Assertion macros used by the LC-3 core controller
`ifndef LC3_INSTRUCTION_CORE_MACROS_SVH
`define LC3_INSTRUCTION_CORE_MACROS_SVH
// same-cycle implication, clocked on clk, off during reset
`define LC3_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LC3_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> hdl/lc3_pkg.sv
// Types, opcodes and helpers for the LC-3 instruction core
`timescale 1ns / 1ps
package lc3_pkg;
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_EXEC  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [3:0] OP_BR  = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd1;
	localparam logic [3:0] OP_LD  = 4'd2;
	localparam logic [3:0] OP_ST  = 4'd3;
	localparam logic [3:0] OP_JSR = 4'd4;
	localparam logic [3:0] OP_AND = 4'd5;
	localparam logic [3:0] OP_LDR = 4'd6;
	localparam logic [3:0] OP_STR = 4'd7;
	localparam logic [3:0] OP_NOT = 4'd9;
	localparam logic [3:0] OP_LDI = 4'd10;
	localparam logic [3:0] OP_STI = 4'd11;
	localparam logic [3:0] OP_JMP = 4'd12;
	localparam logic [3:0] OP_LEA = 4'd14;
	localparam logic [3:0] OP_TRAP = 4'd15;

	localparam logic [7:0] VEC_GETC = 8'h20;
	localparam logic [7:0] VEC_OUT  = 8'h21;
	localparam logic [7:0] VEC_IN   = 8'h23;
	localparam logic [7:0] VEC_HALT = 8'h25;

	localparam logic [15:0] START_PC_RESET = 16'h3000;
	localparam logic [15:0] KBSR_ADDR      = 16'hFE00;
	localparam logic [15:0] KBDR_ADDR      = 16'hFE02;
	localparam logic [15:0] KBSR_READY     = 16'h8000;

	localparam logic [2:0] CC_POS = 3'd1;
	localparam logic [2:0] CC_ZER = 3'd2;
	localparam logic [2:0] CC_NEG = 3'd4;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] addr;
		logic [15:0] data;
		logic        key_ready;
		logic [7:0]  key_char;
	} req_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic [15:0] pc_value;
		logic [2:0]  cond_flags;
		logic        char_valid;
		logic [7:0]  char_out;
		logic        key_taken;
		logic        halted;
		logic        bad_opcode;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic latch;     // capture request, clear result flags
		logic wr_cmd;    // host memory write
		logic rd_cmd;    // host memory read issue
		logic rd_cap;    // capture host read data
		logic ld_req;    // start a load at mar
		logic ld_kbd;    // write key_char into KBDR
		logic ld_cap;    // capture load data into mdr
		logic ir_load;
		logic mar_ea;
		logic mar_mdr;
		logic store;
		logic commit;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       halted;
		logic       kbsr_hit;
		logic       key_ready;
		logic [3:0] op;
	} dp_stat_t;

	function automatic logic [2:0] cc_of(input logic [15:0] v);
		logic [2:0] c;
		if (v == 16'd0) c = CC_ZER;
		else if (v[15]) c = CC_NEG;
		else c = CC_POS;
		return c;
	endfunction
endpackage

>>> hdl/lc3_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module lc3_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		else rdata <= mem_q[addr];
	end
endmodule

>>> hdl/lc3_ctrl.sv
// Controller state machine sequencing commands and instruction phases
`timescale 1ns / 1ps
module lc3_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           cmd,
	input  lc3_pkg::dp_stat_t    stat,
	output lc3_pkg::ctrl_cmd_t   ctl,
	output logic                 busy,
	output logic                 done
);
	import lc3_pkg::*;
	`include "lc3_instruction_core_macros.svh"

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WR     = 4'd1;
	localparam logic [3:0] S_RD     = 4'd2;
	localparam logic [3:0] S_RDW    = 4'd3;
	localparam logic [3:0] S_LDREQ  = 4'd4;
	localparam logic [3:0] S_KBD    = 4'd5;
	localparam logic [3:0] S_LDWAIT = 4'd6;
	localparam logic [3:0] S_LDDONE = 4'd7;
	localparam logic [3:0] S_DECODE = 4'd8;
	localparam logic [3:0] S_STORE  = 4'd9;
	localparam logic [3:0] S_COMMIT = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	localparam logic [1:0] PH_FETCH = 2'd0;
	localparam logic [1:0] PH_OPND  = 2'd1;
	localparam logic [1:0] PH_IND   = 2'd2;
	localparam logic [1:0] PH_NONE  = 2'd3;

	logic [3:0] state_q, state_d;
	logic [1:0] ph_q, ph_d;

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		ctl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.latch = 1'b1;
					priority if (cmd == CMD_WRITE) state_d = S_WR;
					else if (cmd == CMD_READ) state_d = S_RD;
					else if (cmd == CMD_EXEC && !stat.halted) begin
						state_d = S_LDREQ;
						ph_d    = PH_FETCH;
					end else state_d = S_DONE;
				end
			end
			S_WR: begin
				ctl.wr_cmd = 1'b1;
				state_d    = S_DONE;
			end
			S_RD: begin
				ctl.rd_cmd = 1'b1;
				state_d    = S_RDW;
			end
			S_RDW: begin
				ctl.rd_cap = 1'b1;
				state_d    = S_DONE;
			end
			S_LDREQ: begin
				ctl.ld_req = 1'b1;
				// status word is known without a read
				priority if (stat.kbsr_hit && stat.key_ready) state_d = S_KBD;
				else if (stat.kbsr_hit) state_d = S_LDDONE;
				else state_d = S_LDWAIT;
			end
			S_KBD: begin
				ctl.ld_kbd = 1'b1;
				state_d    = S_LDDONE;
			end
			S_LDWAIT: begin
				ctl.ld_cap = 1'b1;
				state_d    = S_LDDONE;
			end
			S_LDDONE: begin
				priority if (ph_q == PH_FETCH) begin
					ctl.ir_load = 1'b1;
					state_d     = S_DECODE;
				end else if (ph_q == PH_OPND && stat.op == OP_LDI) begin
					ctl.mar_mdr = 1'b1;
					ph_d        = PH_IND;
					state_d     = S_LDREQ;
				end else if (ph_q == PH_OPND && stat.op == OP_STI) begin
					ctl.mar_mdr = 1'b1;
					state_d     = S_STORE;
				end else state_d = S_COMMIT;
			end
			S_DECODE: begin
				priority if (stat.op == OP_LD || stat.op == OP_LDI || stat.op == OP_LDR
						|| stat.op == OP_STI) begin
					ctl.mar_ea = 1'b1;
					ph_d       = PH_OPND;
					state_d    = S_LDREQ;
				end else if (stat.op == OP_ST || stat.op == OP_STR) begin
					ctl.mar_ea = 1'b1;
					state_d    = S_STORE;
				end else state_d = S_COMMIT;
			end
			S_STORE: begin
				ctl.store = 1'b1;
				state_d   = S_COMMIT;
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				ph_d    = PH_NONE;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ph_q    <= PH_NONE;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	`LC3_ASSERT_NXT(a_accept_leaves_idle, state_q == S_IDLE && start, busy, "start not taken")
	`LC3_ASSERT_NXT(a_done_returns_idle, done, !busy, "no return to idle after done")
	`LC3_ASSERT_IMP(a_load_has_phase, state_q == S_LDREQ, ph_q != PH_NONE, "load without phase")
endmodule

>>> hdl/lc3_dp.sv
// Datapath: register file, PC, condition code, memory and result registers
`timescale 1ns / 1ps
module lc3_dp #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lc3_pkg::req_t       req,
	input  lc3_pkg::ctrl_cmd_t  ctl,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	output lc3_pkg::dp_stat_t   stat,
	output lc3_pkg::rsp_t       rsp
);
	import lc3_pkg::*;

	logic [15:0] regs_q [8];
	logic [15:0] pc_q, ir_q, mar_q, mdr_q, rd_q;
	logic [2:0]  cc_q;
	logic        halt_q, cv_q, key_q, bad_q;
	logic [7:0]  co_q;
	req_t        req_q;

	logic [3:0]  op;
	logic [2:0]  dr, sr1;
	logic [15:0] pc1, off9, src2, base, ea6, alu, jsr_t, kbsr_val, pc_nxt;
	logic [7:0]  vec;
	logic        mem_we;
	logic [15:0] mem_addr, mem_wdata, mem_rdata;

	assign op   = ir_q[15:12];
	assign dr   = ir_q[11:9];
	assign sr1  = ir_q[8:6];
	assign vec  = ir_q[7:0];
	assign base = regs_q[sr1];
	assign pc1  = pc_q + 16'd1;
	assign off9 = pc1 + {{7{ir_q[8]}}, ir_q[8:0]};
	assign ea6  = base + {{10{ir_q[5]}}, ir_q[5:0]};
	assign src2 = ir_q[5] ? {{11{ir_q[4]}}, ir_q[4:0]} : regs_q[ir_q[2:0]];
	assign jsr_t = ir_q[11] ? pc1 + {{5{ir_q[10]}}, ir_q[10:0]} : base;
	assign kbsr_val = req_q.key_ready ? KBSR_READY : 16'd0;

	always_comb begin
		unique case (op)
			OP_ADD:  alu = base + src2;
			OP_AND:  alu = base & src2;
			default: alu = ~base;
		endcase
	end

	// next PC at commit
	always_comb begin
		pc_nxt = pc1;
		unique case (op)
			OP_BR:   if ((cc_q & dr) != 3'd0) pc_nxt = off9;
			OP_JMP:  pc_nxt = base;
			OP_JSR:  pc_nxt = jsr_t;
			// no key: stay on the trap and retry next time
			OP_TRAP: if ((vec == VEC_GETC || vec == VEC_IN) && !req_q.key_ready) pc_nxt = pc_q;
			default: ;
		endcase
	end

	assign stat.halted    = halt_q;
	assign stat.kbsr_hit  = (mar_q == KBSR_ADDR);
	assign stat.key_ready = req_q.key_ready;
	assign stat.op        = op;

	always_comb begin
		mem_we    = ctl.wr_cmd | ctl.ld_kbd | ctl.store | (ctl.ld_req & stat.kbsr_hit);
		mem_addr  = mar_q;
		mem_wdata = regs_q[dr];
		priority if (ctl.wr_cmd) begin
			mem_addr  = req_q.addr;
			mem_wdata = req_q.data;
		end else if (ctl.rd_cmd) begin
			mem_addr = req_q.addr;
		end else if (ctl.ld_kbd) begin
			mem_addr  = KBDR_ADDR;
			mem_wdata = {8'd0, req_q.key_char};
		end else begin
			mem_wdata = ctl.ld_req ? kbsr_val : regs_q[dr];
		end
	end

	lc3_ram #(.WIDTH(16), .DEPTH(2 ** MEM_ADDR_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr[MEM_ADDR_BITS-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.latch) req_q <= req;
		if (ctl.ir_load) ir_q <= mdr_q;
		if (ctl.ld_req && stat.kbsr_hit) mdr_q <= kbsr_val;
		else if (ctl.ld_cap) mdr_q <= mem_rdata;
		priority if (ctl.latch) mar_q <= pc_q;
		else if (ctl.mar_ea) mar_q <= (op == OP_LDR || op == OP_STR) ? ea6 : off9;
		else if (ctl.mar_mdr) mar_q <= mdr_q;
		else mar_q <= mar_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) regs_q[i] <= 16'd0;
			pc_q   <= START_PC_RESET;
			cc_q   <= 3'd0;
			halt_q <= 1'b0;
			cv_q   <= 1'b0;
			co_q   <= 8'd0;
			key_q  <= 1'b0;
			bad_q  <= 1'b0;
			rd_q   <= 16'd0;
		end else begin
			if (cfg_we) pc_q <= cfg_data;
			if (ctl.latch) begin
				cv_q  <= 1'b0;
				co_q  <= 8'd0;
				key_q <= 1'b0;
				bad_q <= 1'b0;
				rd_q  <= 16'd0;
			end
			if (ctl.rd_cap) rd_q <= mem_rdata;
			if (ctl.ld_kbd) key_q <= 1'b1;
			if (ctl.commit) begin
				pc_q <= pc_nxt;
				unique case (op)
					OP_BR, OP_JMP: ;
					OP_ADD, OP_AND, OP_NOT: begin
						regs_q[dr] <= alu;
						cc_q       <= cc_of(alu);
					end
					OP_LD, OP_LDI, OP_LDR: begin
						regs_q[dr] <= mdr_q;
						cc_q       <= cc_of(mdr_q);
					end
					OP_LEA: begin
						regs_q[dr] <= off9;
						cc_q       <= cc_of(off9);
					end
					OP_ST, OP_STI, OP_STR: ;
					OP_JSR: regs_q[7] <= pc1;
					OP_TRAP: begin
						unique case (vec)
							VEC_GETC, VEC_IN: begin
								if (req_q.key_ready) begin
									regs_q[0] <= {8'd0, req_q.key_char};
									key_q     <= 1'b1;
									if (vec == VEC_IN) begin
										cv_q <= 1'b1;
										co_q <= req_q.key_char;
									end
								end
							end
							VEC_OUT: begin
								cv_q <= 1'b1;
								co_q <= regs_q[0][7:0];
							end
							VEC_HALT: halt_q <= 1'b1;
							default: ;
						endcase
					end
					default: bad_q <= 1'b1;
				endcase
			end
		end
	end

	assign rsp.read_data  = rd_q;
	assign rsp.pc_value   = pc_q;
	assign rsp.cond_flags = cc_q;
	assign rsp.char_valid = cv_q;
	assign rsp.char_out   = co_q;
	assign rsp.key_taken  = key_q;
	assign rsp.halted     = halt_q;
	assign rsp.bad_opcode = bad_q;
endmodule

>>> hdl/lc3_instruction_core.sv
// LC-3 instruction core top level
// Usage: pulse start with a request word on req while busy is low. The word
// is a memory write, a memory read, or an execute of one instruction at PC.
// When the work is finished, done is high for exactly one cycle with the
// result word on rsp; the receiver cannot hold it off, and busy falls in the
// next cycle so a new word can be taken.
// An execute runs through the sequence of accesses to the one single-port
// memory: fetch, an optional indirect read and a data access. Each read
// passes through a request and a capture state; a keyboard status access
// is served without a memory read.
// One word is in work at a time.
// cfg_data loads the program counter; cfg_ready is high while idle.
// Reset clears registers, flags and the halt state and sets PC to 0x3000;
// memory contents are undefined until written.
`timescale 1ns / 1ps
module lc3_instruction_core #(
	parameter int MEM_ADDR_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lc3_pkg::req_t   req,
	output logic            done,
	output lc3_pkg::rsp_t   rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [15:0]     cfg_data
);
	import lc3_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	assign cfg_ready = !busy;

	lc3_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (req.cmd),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	lc3_dp #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.ctl      (ctl),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.rsp      (rsp)
	);
endmodule
